// ===== sv/srtc_pkg.sv =====
`default_nettype none

package srtc_pkg;

    // Pin selector codes
    localparam logic [2:0] PIN_CLOCK  = 3'd0;
    localparam logic [2:0] PIN_STROBE = 3'd1;
    localparam logic [2:0] PIN_C0     = 3'd2;
    localparam logic [2:0] PIN_C1     = 3'd3;
    localparam logic [2:0] PIN_C2     = 3'd4;
    localparam logic [2:0] PIN_DIN    = 3'd5;

    // Latched command modes that the block acts on
    localparam logic [2:0] MODE_SHIFT     = 3'd1;
    localparam logic [2:0] MODE_TIME_READ = 3'd3;

    localparam int unsigned HalfWidth = 20;
    localparam int unsigned Radix     = 10;

    // Reciprocal of ten scaled by 2^11, exact for inputs below 1024
    localparam logic [7:0] RecipTen  = 8'd205;
    localparam int unsigned RecipShift = 11;

    typedef logic [HalfWidth-1:0] half_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } bcd_t;

    // Split a six-bit binary value into two BCD digits
    function automatic bcd_t to_bcd(input logic [5:0] value);
        logic [13:0] prod;
        logic [2:0]  quot;
        logic [5:0]  rem;
        bcd_t        res;
        prod = {8'd0, value} * {6'd0, RecipTen};
        quot = prod[RecipShift +: 3];
        rem  = value - ({3'd0, quot} * 6'(Radix));
        res.tens = {1'b0, quot};
        res.ones = rem[3:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/srtc_pin_if.sv =====
`default_nettype none

interface srtc_pin_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic       level;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [3:0] month;

    modport source (
        output valid, cmd, level, second, minute, hour, day, weekday, month,
        input  ready
    );
    modport sink (
        input  valid, cmd, level, second, minute, hour, day, weekday, month,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/srtc_data_if.sv =====
`default_nettype none

interface srtc_data_if;
    logic valid;
    logic ready;
    logic data_out;

    modport source (
        output valid, data_out,
        input  ready
    );
    modport sink (
        input  valid, data_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/serial_rtc_shift_interface.sv =====
// Channel    Dir  Payload                                              Meaning
// pin_ch     in   cmd, level, second, minute, hour, day, weekday,      one pin change request
//                 month
// data_ch    out  data_out                                             bit shifted out on clock rise
//
// One request is taken every cycle unless stalled; a rising clock pin request gives its bit on
// data_ch in the following cycle. The single output register sets the rate:
// pin_ch stays ready while that register is empty or being drained in the same cycle.
// A stall on data_ch holds the waiting bit and blocks pin_ch only while it persists.
// Reset (rst_n low, asynchronous) sets all pin levels high, clears command, mode
// and shift register, and empties the output register.
`default_nettype none

module serial_rtc_shift_interface (
    input  wire logic    clk,
    input  wire logic    rst_n,
    srtc_pin_if.sink     pin_ch,
    srtc_data_if.source  data_ch
);

    logic                clock_level_reg,  clock_level_next;
    logic                strobe_level_reg, strobe_level_next;
    logic                din_level_reg,    din_level_next;
    logic [2:0]          command_reg,      command_next;
    logic [2:0]          mode_reg,         mode_next;
    srtc_pkg::half_t     shift_low_reg,    shift_low_next;
    srtc_pkg::half_t     shift_high_reg,   shift_high_next;
    logic                out_valid_reg,    out_valid_next;
    logic                data_out_reg,     data_out_next;

    logic                accept;
    logic                clock_rise;
    logic                strobe_rise;
    srtc_pkg::bcd_t      sec_bcd, min_bcd, hour_bcd, day_bcd;

    // Take a new request whenever the output slot is free or drains this cycle
    assign pin_ch.ready  = !out_valid_reg || data_ch.ready;
    assign accept        = pin_ch.valid && pin_ch.ready;

    assign data_ch.valid    = out_valid_reg;
    assign data_ch.data_out = data_out_reg;

    assign clock_rise  = !clock_level_reg  && pin_ch.level;
    assign strobe_rise = !strobe_level_reg && pin_ch.level;

    // BCD digits for the time read load
    assign sec_bcd  = srtc_pkg::to_bcd(pin_ch.second);
    assign min_bcd  = srtc_pkg::to_bcd(pin_ch.minute);
    assign hour_bcd = srtc_pkg::to_bcd({1'b0, pin_ch.hour});
    assign day_bcd  = srtc_pkg::to_bcd({1'b0, pin_ch.day});

    always_comb
    begin
        clock_level_next  = clock_level_reg;
        strobe_level_next = strobe_level_reg;
        din_level_next    = din_level_reg;
        command_next      = command_reg;
        mode_next         = mode_reg;
        shift_low_next    = shift_low_reg;
        shift_high_next   = shift_high_reg;
        data_out_next     = data_out_reg;
        // drop the waiting bit once the sink takes it
        out_valid_next    = out_valid_reg && !data_ch.ready;

        if (accept)
        begin
            case (pin_ch.cmd)
                srtc_pkg::PIN_CLOCK:
                begin
                    if (clock_rise)
                    begin
                        // emit bit 0 before any shift
                        out_valid_next = 1'b1;
                        data_out_next  = shift_low_reg[0];
                        if (mode_reg == srtc_pkg::MODE_SHIFT)
                        begin
                            shift_low_next  = {shift_high_reg[0], shift_low_reg[19:1]};
                            shift_high_next = {din_level_reg, shift_high_reg[19:1]};
                        end
                    end
                    clock_level_next = pin_ch.level;
                end
                srtc_pkg::PIN_STROBE:
                begin
                    if (strobe_rise)
                    begin
                        // latch the command; a time read loads the register
                        mode_next = command_reg;
                        if (command_reg == srtc_pkg::MODE_TIME_READ)
                        begin
                            shift_low_next  = {hour_bcd.ones, min_bcd.tens, min_bcd.ones,
                                               sec_bcd.tens, sec_bcd.ones};
                            shift_high_next = {pin_ch.month, 1'b0, pin_ch.weekday,
                                               day_bcd.tens, day_bcd.ones, hour_bcd.tens};
                        end
                    end
                    strobe_level_next = pin_ch.level;
                end
                srtc_pkg::PIN_C0:  command_next[0] = pin_ch.level;
                srtc_pkg::PIN_C1:  command_next[1] = pin_ch.level;
                srtc_pkg::PIN_C2:  command_next[2] = pin_ch.level;
                srtc_pkg::PIN_DIN: din_level_next  = pin_ch.level;
                default:
                begin
                    // unused selectors change nothing
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_level_reg  <= 1'b1;
            strobe_level_reg <= 1'b1;
            din_level_reg    <= 1'b1;
            command_reg      <= '0;
            mode_reg         <= '0;
            shift_low_reg    <= '0;
            shift_high_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clock_level_reg  <= clock_level_next;
            strobe_level_reg <= strobe_level_next;
            din_level_reg    <= din_level_next;
            command_reg      <= command_next;
            mode_reg         <= mode_next;
            shift_low_reg    <= shift_low_next;
            shift_high_reg   <= shift_high_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
    end

endmodule

`default_nettype wire

// ===== sv/srtc_checker.sv =====
`default_nettype none

module srtc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pin_valid,
    input wire logic       pin_ready,
    input wire logic [2:0] pin_cmd,
    input wire logic       pin_level,
    input wire logic       data_valid,
    input wire logic       data_ready,
    input wire logic       data_out
);

    // No bit is pending while reset is held
    assert property (@(posedge clk) !rst_n |-> !data_valid)
        else $error("output valid during reset");

    // An empty output slot never blocks requests
    assert property (@(posedge clk) disable iff (!rst_n) !data_valid |-> pin_ready)
        else $error("pin channel blocked with empty output");

    // A new bit appears only after an accepted high clock pin request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(data_valid) |-> $past(pin_valid && pin_ready && pin_level &&
                                    pin_cmd == srtc_pkg::PIN_CLOCK))
        else $error("output bit without clock request");

    // Requests on other pins give no bit
    assert property (@(posedge clk) disable iff (!rst_n)
        pin_valid && pin_ready && pin_cmd != srtc_pkg::PIN_CLOCK &&
        (!data_valid || data_ready) |=> !data_valid)
        else $error("output bit from a non-clock request");

    // A stalled bit holds
    assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && !data_ready |=> data_valid && $stable(data_out))
        else $error("stalled output bit changed");

endmodule

bind serial_rtc_shift_interface srtc_checker u_srtc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pin_valid  (pin_ch.valid),
    .pin_ready  (pin_ch.ready),
    .pin_cmd    (pin_ch.cmd),
    .pin_level  (pin_ch.level),
    .data_valid (data_ch.valid),
    .data_ready (data_ch.ready),
    .data_out   (data_ch.data_out)
);

`default_nettype wire

// ===== tb/serial_rtc_shift_interface_check.sv =====
`default_nettype none

module serial_rtc_shift_interface_check (
    input  wire logic clk,
    input  wire logic rst_n,
    srtc_pin_if       pin_ch,
    srtc_data_if      data_ch,
    output int        mismatches,
    output int        bits_pending
);

    // Pin levels, command, mode and the 40-bit shift register
    logic        clk_lvl;
    logic        stb_lvl;
    logic        din_lvl;
    logic [2:0]  cmd_bits;
    logic [2:0]  mode;
    logic [39:0] shreg;
    logic        due_bits[$];
    logic        want;

    initial mismatches = 0;
    initial bits_pending = 0;

    function automatic logic [7:0] bcd_pair(input logic [5:0] v);
        return {4'(v / 6'd10), 4'(v % 6'd10)};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_lvl  = 1'b1;
            stb_lvl  = 1'b1;
            din_lvl  = 1'b1;
            cmd_bits = '0;
            mode     = '0;
            shreg    = '0;
            due_bits.delete();
            bits_pending = 0;
        end
        else
        begin
            // Drain first: a bit leaving now was caused by an earlier request
            if (data_ch.valid && data_ch.ready)
            begin
                if (due_bits.size() == 0)
                    report_mismatch("data_out given with no clock rise pending");
                else
                begin
                    want = due_bits.pop_front();
                    if (data_ch.data_out !== want)
                        report_mismatch($sformatf("data_out %b, expected %b",
                                                  data_ch.data_out, want));
                end
            end

            if (pin_ch.valid && pin_ch.ready)
            begin
                case (pin_ch.cmd)
                    srtc_pkg::PIN_CLOCK:
                    begin
                        if (!clk_lvl && pin_ch.level)
                        begin
                            due_bits.push_back(shreg[0]);
                            if (mode == srtc_pkg::MODE_SHIFT)
                                shreg = {din_lvl, shreg[39:1]};
                        end
                        clk_lvl = pin_ch.level;
                    end
                    srtc_pkg::PIN_STROBE:
                    begin
                        if (!stb_lvl && pin_ch.level)
                        begin
                            mode = cmd_bits;
                            if (mode == srtc_pkg::MODE_TIME_READ)
                                shreg = {pin_ch.month, 1'b0, pin_ch.weekday,
                                         bcd_pair(6'(pin_ch.day)),
                                         bcd_pair(6'(pin_ch.hour)),
                                         bcd_pair(pin_ch.minute),
                                         bcd_pair(pin_ch.second)};
                        end
                        stb_lvl = pin_ch.level;
                    end
                    srtc_pkg::PIN_C0:  cmd_bits[0] = pin_ch.level;
                    srtc_pkg::PIN_C1:  cmd_bits[1] = pin_ch.level;
                    srtc_pkg::PIN_C2:  cmd_bits[2] = pin_ch.level;
                    srtc_pkg::PIN_DIN: din_lvl = pin_ch.level;
                    default: ;
                endcase
            end
            bits_pending = due_bits.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/serial_rtc_shift_interface_tb.sv =====
`default_nettype none

module serial_rtc_shift_interface_tb;

    // Calendar fields carried by every pin request, in port order
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [3:0] month;
    } clock_time_t;

    logic clk = 1'b0;
    logic rst_n;

    // Idle odds in percent per cycle, and the receiver's long hold-off
    int tx_idle_pct       = 0;
    int rx_idle_pct       = 0;
    int hold_ready_cycles = 0;
    int requests_sent     = 0;
    int mismatches;
    int bits_pending;

    srtc_pin_if  pin_ch ();
    srtc_data_if data_ch ();

    serial_rtc_shift_interface dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pin_ch  (pin_ch),
        .data_ch (data_ch)
    );

    // Watch both channels, predict every data_out bit and count mismatches
    serial_rtc_shift_interface_check rtc_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .pin_ch       (pin_ch),
        .data_ch      (data_ch),
        .mismatches   (mismatches),
        .bits_pending (bits_pending)
    );

    always #5 clk = ~clk;

    // Mostly a real calendar time; otherwise raw bits so the digit split
    // also sees values beyond the calendar ranges
    function automatic clock_time_t any_time();
        clock_time_t t;
        if ($urandom_range(99) < 75)
        begin
            t.second  = 6'($urandom_range(59));
            t.minute  = 6'($urandom_range(59));
            t.hour    = 5'($urandom_range(23));
            t.day     = 5'($urandom_range(31, 1));
            t.weekday = 3'($urandom_range(6));
            t.month   = 4'($urandom_range(12, 1));
        end
        else
            t = 29'($urandom);
        return t;
    endfunction

    // Offer one pin request and hold it until the block takes it. Valid
    // stays high between back-to-back requests; drop it only while idling.
    task automatic send_request(input logic [2:0] pin, input logic lvl,
                                input clock_time_t t);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pin_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pin_ch.valid   <= 1'b1;
        pin_ch.cmd     <= pin;
        pin_ch.level   <= lvl;
        pin_ch.second  <= t.second;
        pin_ch.minute  <= t.minute;
        pin_ch.hour    <= t.hour;
        pin_ch.day     <= t.day;
        pin_ch.weekday <= t.weekday;
        pin_ch.month   <= t.month;
        @(posedge clk);
        while (!pin_ch.ready)
            @(posedge clk);
        // Unused selectors are ignored by the block; leave them out of the tally
        if (pin <= srtc_pkg::PIN_DIN)
            requests_sent++;
    endtask

    // Full clock pulses, low then high; now and then move data in first so
    // the bit entering at the top of the register varies
    task automatic clock_pulses(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                send_request(srtc_pkg::PIN_DIN, 1'($urandom_range(1)), any_time());
            send_request(srtc_pkg::PIN_CLOCK, 1'b0, any_time());
            send_request(srtc_pkg::PIN_CLOCK, 1'b1, any_time());
        end
    endtask

    // Set the three command pins, then raise the strobe from low to latch them
    task automatic latch_mode(input logic [2:0] m, input clock_time_t t);
        send_request(srtc_pkg::PIN_C0, m[0], any_time());
        send_request(srtc_pkg::PIN_C1, m[1], any_time());
        send_request(srtc_pkg::PIN_C2, m[2], any_time());
        send_request(srtc_pkg::PIN_STROBE, 1'b0, any_time());
        send_request(srtc_pkg::PIN_STROBE, 1'b1, t);
    endtask

    // Stop offering requests until every predicted bit has come out; the
    // first edge lets the last accepted request reach the prediction
    task automatic drain_results();
        pin_ch.valid <= 1'b0;
        @(posedge clk);
        while (bits_pending != 0)
            @(posedge clk);
    endtask

    // Receiver: random ready, or a long counted hold-off when one is asked for
    initial
    begin
        data_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ready_cycles > 0)
            begin
                data_ch.ready <= 1'b0;
                hold_ready_cycles--;
            end
            else
                data_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int          r;
        int          n;
        int          phase;
        int          phase_end[3];
        int          tx_pct[3];
        int          rx_pct[3];
        clock_time_t t_max;
        clock_time_t t_over;

        phase_end = '{580, 1165, 1750};
        tx_pct    = '{6, 59, 0};
        rx_pct    = '{59, 6, 0};
        t_max     = '{6'd59, 6'd59, 5'd23, 5'd31, 3'd6, 4'd12};
        t_over    = '{6'd63, 6'd63, 5'd31, 5'd0, 3'd7, 4'd15};

        rst_n          <= 1'b0;
        pin_ch.valid   <= 1'b0;
        pin_ch.cmd     <= srtc_pkg::PIN_CLOCK;
        pin_ch.level   <= 1'b0;
        pin_ch.second  <= '0;
        pin_ch.minute  <= '0;
        pin_ch.hour    <= '0;
        pin_ch.day     <= '0;
        pin_ch.weekday <= '0;
        pin_ch.month   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = tx_pct[0];
        rx_idle_pct = rx_pct[0];

        // Directed: load the largest calendar time in time-read mode
        latch_mode(srtc_pkg::MODE_TIME_READ, t_max);
        // Clock is high out of reset: high again is no edge, so no bit
        send_request(srtc_pkg::PIN_CLOCK, 1'b1, any_time());
        // Time-read mode gives bit 0 without shifting
        clock_pulses(1);
        // Strobe already high: no edge, mode and register hold
        send_request(srtc_pkg::PIN_STROBE, 1'b1, t_over);
        // Switch to shift mode without reloading
        send_request(srtc_pkg::PIN_C1, 1'b0, any_time());
        send_request(srtc_pkg::PIN_STROBE, 1'b0, any_time());
        send_request(srtc_pkg::PIN_STROBE, 1'b1, any_time());
        send_request(srtc_pkg::PIN_DIN, 1'b0, any_time());
        clock_pulses(2);
        // Unused selectors change nothing
        send_request(3'd6, 1'b1, t_over);
        send_request(3'd7, 1'b0, t_over);
        // Reload with every field beyond its calendar range
        send_request(srtc_pkg::PIN_C1, 1'b1, any_time());
        send_request(srtc_pkg::PIN_STROBE, 1'b0, any_time());
        send_request(srtc_pkg::PIN_STROBE, 1'b1, t_over);
        // Latch mode 7: clock rises give bit 0 and never shift
        send_request(srtc_pkg::PIN_C2, 1'b1, any_time());
        send_request(srtc_pkg::PIN_STROBE, 1'b0, any_time());
        send_request(srtc_pkg::PIN_STROBE, 1'b1, any_time());
        clock_pulses(1);

        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = tx_pct[phase];
            rx_idle_pct = rx_pct[phase];

            if (phase == 2)
            begin
                // Hold the receiver off for a long stretch while clock rises
                // keep coming, so the output register fills and pin_ch stalls
                hold_ready_cycles = 200;
                latch_mode(srtc_pkg::MODE_SHIFT, any_time());
                clock_pulses(20);
            end

            while (requests_sent < phase_end[phase])
            begin
                r = $urandom_range(99);
                if (r < 55)
                begin
                    // Proper read: load the time, switch to shift, clock it out
                    latch_mode(srtc_pkg::MODE_TIME_READ, any_time());
                    latch_mode(srtc_pkg::MODE_SHIFT, any_time());
                    clock_pulses($urandom_range(45, 1));
                end
                else if (r < 70)
                begin
                    // Any mode, including the ones that never shift
                    latch_mode(3'($urandom_range(7)), any_time());
                    clock_pulses($urandom_range(6, 1));
                end
                else if (r < 90)
                begin
                    // Noise: any selector, any level
                    n = $urandom_range(8, 1);
                    repeat (n)
                        send_request(3'($urandom_range(7)), 1'($urandom_range(1)),
                                     any_time());
                end
                else
                begin
                    // Broken read: never leave time-read mode, repeat high levels
                    latch_mode(srtc_pkg::MODE_TIME_READ, any_time());
                    send_request(srtc_pkg::PIN_STROBE, 1'b1, any_time());
                    send_request(srtc_pkg::PIN_CLOCK, 1'b1, any_time());
                    clock_pulses($urandom_range(3, 1));
                end
            end

            // Pause the sender until every outstanding bit has arrived
            if (phase == 0)
                drain_results();
        end

        drain_results();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/srtc_pkg.sv
sv/srtc_pin_if.sv
sv/srtc_data_if.sv
sv/serial_rtc_shift_interface.sv
sv/srtc_checker.sv
tb/serial_rtc_shift_interface_check.sv
tb/serial_rtc_shift_interface_tb.sv
